// File: rtl/htq_pkg.sv
// Shared types and command codes for the heap timer queue.
// Used by the controller and by the top level; depends on nothing.
`default_nettype none

package htq_pkg;

    localparam int CMD_W   = 3;
    localparam int ID_W    = 8;
    localparam int DELAY_W = 31;
    localparam int STAT_W  = 2;
    localparam int DUE_W   = 31;
    localparam int CNT_W   = 7;

    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADJUST = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FIRE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DROP   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ID_W-1:0]    timer_id;
        logic [DELAY_W-1:0] delay_ms;
    } t_in;

    typedef struct packed {
        logic [ID_W-1:0]   fired_id;
        logic              fired;
        logic              last;
        logic [STAT_W-1:0] status;
        logic              queue_empty;
        logic [DUE_W-1:0]  next_due_ms;
        logic [CNT_W-1:0]  timer_count;
    } t_out;

    typedef struct packed {
        logic valid;
        t_out data;
    } t_emit;

endpackage

`default_nettype wire

// File: rtl/heap_timer_queue_top.sv
// Top level of the heap timer queue: command sequencer and result register.
// Uses htq_pkg and htq_ctrl.
//
//   Port group   Direction  Carries
//   i_in_*       in         one command transfer (cmd, timer_id, delay_ms)
//   o_out_*      out        one result transfer (fired id, flags, status, due, count)
//
// Commands are taken one at a time. The run time of a command grows with each heap
// level crossed by a sift, and a tick adds a removal and a sift for each expired
// timer. The heap memory, one read port per copy, sets the pace of each sift step.
// After reset the id table is swept, one entry a cycle, over all ID_COUNT entries before
// the first command is taken. A stalled result holds the sequencer in its report step.
`default_nettype none

module heap_timer_queue_top
    import htq_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int ID_COUNT  = 256,
    parameter int TIME_BITS = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data
);

    t_emit emit;
    logic  out_ready;
    logic  r_ovalid;
    t_out  r_out;

    assign out_ready = !r_ovalid || !i_out_stall;

    htq_ctrl #(
        .CAPACITY(CAPACITY),
        .ID_COUNT(ID_COUNT),
        .TIME_BITS(TIME_BITS)
    ) u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(i_in_data),
        .i_out_ready(out_ready),
        .o_emit(emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_ready) begin
            r_ovalid <= emit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && emit.valid) begin
            r_out <= emit.data;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: rtl/htq_ram.sv
// Simple synchronous RAM with one write port and one registered read port.
// Stands alone; the controller instantiates it for the heap and the id table.
`default_nettype none

module htq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/htq_ctrl.sv
// Command sequencer of the heap timer queue: heap and id table memories,
// sift-up and sift-down loops, clock and result generation. Uses htq_pkg, htq_ram.
`default_nettype none

module htq_ctrl
    import htq_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int ID_COUNT  = 256,
    parameter int TIME_BITS = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    input  wire logic i_out_ready,
    output t_emit     o_emit
);

    localparam int AW = $clog2(CAPACITY);
    localparam int SW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(ID_COUNT);
    localparam int CW = $clog2(ID_COUNT + 1);
    localparam int XW = (IW > ID_W) ? IW : ID_W;
    localparam int DW = (TIME_BITS > DELAY_W) ? TIME_BITS : DELAY_W;
    localparam logic [TIME_BITS-1:0] T_SIGN = {1'b1, {(TIME_BITS-1){1'b0}}};

    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [TIME_BITS-1:0] exp;
    } t_slot;

    typedef struct packed {
        logic          present;
        logic [AW-1:0] pos;
    } t_where;

    typedef enum logic [14:0] {
        S_INIT   = 15'h0001,
        S_IDLE   = 15'h0002,
        S_LOOK   = 15'h0004,
        S_RM     = 15'h0008,
        S_RM2    = 15'h0010,
        S_SD_RD  = 15'h0020,
        S_SD_CMP = 15'h0040,
        S_SU_RD  = 15'h0080,
        S_SU_CMP = 15'h0100,
        S_FIN    = 15'h0200,
        S_FIN2   = 15'h0400,
        S_CQ_RD  = 15'h0800,
        S_CQ_WR  = 15'h1000,
        S_REP_RD = 15'h2000,
        S_REP    = 15'h4000
    } t_state;

    function automatic logic earlier(input t_slot a, input t_slot b,
                                     input logic [TIME_BITS-1:0] now);
        logic [TIME_BITS-1:0] ka;
        logic [TIME_BITS-1:0] kb;
        ka = (a.exp - now) ^ T_SIGN;
        kb = (b.exp - now) ^ T_SIGN;
        return ka < kb;
    endfunction

    function automatic logic [IW-1:0] idx_of(input logic [ID_W-1:0] id);
        logic [XW-1:0] x;
        x = XW'(id);
        return x[IW-1:0];
    endfunction

    t_state r_state, n_state;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [SW-1:0]        r_size, n_size;
    logic [SW-1:0]        r_bound, n_bound;
    logic [CMD_W-1:0]     r_cmd, n_cmd;
    logic [ID_W-1:0]      r_id, n_id;
    logic                 r_id_ok, n_id_ok;
    logic [TIME_BITS-1:0] r_delay, n_delay;
    logic [AW-1:0]        r_i, n_i;
    t_slot                r_elem, n_elem;
    logic [ID_W-1:0]      r_rid, n_rid;
    logic                 r_rm, n_rm;
    logic                 r_moved, n_moved;
    logic [ID_W-1:0]      r_fid, n_fid;
    logic                 r_fired, n_fired;
    logic [STAT_W-1:0]    r_status, n_status;
    logic                 r_pend, n_pend;

    logic          h_we;
    logic [AW-1:0] h_waddr;
    t_slot         h_wdata;
    logic [AW-1:0] ra_a, ra_b;
    t_slot         rd_a, rd_b;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    t_where        w_wdata;
    logic [IW-1:0] w_raddr;
    t_where        rd_w;

    htq_ram #(.WIDTH($bits(t_slot)), .DEPTH(CAPACITY)) u_heap_a (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_raddr(ra_a), .o_rdata(rd_a)
    );

    htq_ram #(.WIDTH($bits(t_slot)), .DEPTH(CAPACITY)) u_heap_b (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_raddr(ra_b), .o_rdata(rd_b)
    );

    htq_ram #(.WIDTH($bits(t_where)), .DEPTH(ID_COUNT)) u_table (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(rd_w)
    );

    logic [AW+1:0]        j_l, j_r, bound_x;
    logic                 has_l, has_r, pick_r;
    t_slot                child;
    logic [AW-1:0]        child_idx;
    logic [AW-1:0]        par;
    logic [TIME_BITS-1:0] d_top, new_exp;
    logic [DW-1:0]        d_ext, dext_in, dsat_in;
    logic                 top_due, known;
    logic [DUE_W-1:0]     due_val;

    always_comb begin
        j_l       = {1'b0, r_i, 1'b1};
        j_r       = j_l + (AW+2)'(1);
        bound_x   = (AW+2)'(r_bound);
        has_l     = j_l < bound_x;
        has_r     = j_r < bound_x;
        pick_r    = has_r && earlier(rd_b, rd_a, r_now);
        child     = pick_r ? rd_b : rd_a;
        child_idx = pick_r ? j_r[AW-1:0] : j_l[AW-1:0];
        par       = (r_i - AW'(1)) >> 1;
        new_exp   = r_now + r_delay;
        known     = r_id_ok && rd_w.present;
        d_top     = rd_a.exp - r_now;
        top_due   = (r_size != '0) && (d_top[TIME_BITS-1] || (d_top == '0));
        d_ext     = DW'(d_top);
        if ((r_size == '0) || d_top[TIME_BITS-1]) begin
            due_val = '0;
        end else if (d_ext > DW'(31'h7FFF_FFFF)) begin
            due_val = '1;
        end else begin
            due_val = d_ext[DUE_W-1:0];
        end
        dext_in = DW'(i_in_data.delay_ms);
        dsat_in = (dext_in > DW'({(TIME_BITS-1){1'b1}})) ?
                  DW'({(TIME_BITS-1){1'b1}}) : dext_in;
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_now    = r_now;
        n_size   = r_size;
        n_bound  = r_bound;
        n_cmd    = r_cmd;
        n_id     = r_id;
        n_id_ok  = r_id_ok;
        n_delay  = r_delay;
        n_i      = r_i;
        n_elem   = r_elem;
        n_rid    = r_rid;
        n_rm     = r_rm;
        n_moved  = r_moved;
        n_fid    = r_fid;
        n_fired  = r_fired;
        n_status = r_status;
        n_pend   = r_pend;
        h_we     = 1'b0;
        h_waddr  = r_i;
        h_wdata  = r_elem;
        ra_a     = '0;
        ra_b     = '0;
        w_we     = 1'b0;
        w_waddr  = '0;
        w_wdata  = '0;
        w_raddr  = idx_of(i_in_data.timer_id);
        o_emit   = '0;

        case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_waddr = r_cnt[IW-1:0];
                n_cnt   = r_cnt + CW'(1);
                if (r_cnt == CW'(ID_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = i_in_data.cmd;
                    n_id     = i_in_data.timer_id;
                    n_id_ok  = 32'(i_in_data.timer_id) < 32'(ID_COUNT);
                    n_delay  = dsat_in[TIME_BITS-1:0];
                    n_fid    = '0;
                    n_fired  = 1'b0;
                    n_status = ST_OK;
                    n_pend   = 1'b0;
                    n_rm     = 1'b0;
                    n_moved  = 1'b0;
                    if (i_in_data.cmd == CMD_TICK) begin
                        n_now = r_now + TIME_BITS'(1);
                    end
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_REP_RD;
                case (r_cmd)
                    CMD_ADD, CMD_ADJUST: begin
                        if (known) begin
                            n_elem  = '{id: r_id, exp: new_exp};
                            n_i     = rd_w.pos;
                            n_bound = r_size;
                            n_state = S_SD_RD;
                        end else if (!r_id_ok || r_cmd == CMD_ADJUST) begin
                            n_status = ST_ABSENT;
                        end else if (r_size == SW'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else begin
                            n_elem  = '{id: r_id, exp: new_exp};
                            n_i     = AW'(r_size);
                            n_size  = r_size + SW'(1);
                            n_state = S_SU_RD;
                        end
                    end
                    CMD_FIRE: begin
                        if (!known) begin
                            n_status = ST_ABSENT;
                        end else begin
                            n_fid   = r_id;
                            n_fired = 1'b1;
                            n_i     = rd_w.pos;
                            n_state = S_RM;
                        end
                    end
                    CMD_DROP: begin
                        if (r_size == '0) begin
                            n_status = ST_ABSENT;
                        end else begin
                            n_i     = '0;
                            n_state = S_RM;
                        end
                    end
                    CMD_CLEAR: begin
                        n_state = S_CQ_RD;
                    end
                    default: begin
                        n_state = S_REP_RD;
                    end
                endcase
            end
            S_RM: begin
                ra_a    = AW'(r_size - SW'(1));
                ra_b    = r_i;
                n_state = S_RM2;
            end
            S_RM2: begin
                n_rid   = rd_b.id;
                n_size  = r_size - SW'(1);
                n_rm    = 1'b1;
                n_moved = 1'b0;
                if (SW'(r_i) < r_size - SW'(1)) begin
                    n_elem  = rd_a;
                    n_bound = r_size - SW'(1);
                    n_state = S_SD_RD;
                end else begin
                    n_state = S_FIN2;
                end
            end
            S_SD_RD: begin
                ra_a = j_l[AW-1:0];
                ra_b = j_r[AW-1:0];
                if (has_l) begin
                    n_state = S_SD_CMP;
                end else begin
                    n_state = r_moved ? S_FIN : S_SU_RD;
                end
            end
            S_SD_CMP: begin
                if (earlier(r_elem, child, r_now)) begin
                    n_state = r_moved ? S_FIN : S_SU_RD;
                end else begin
                    h_we    = 1'b1;
                    h_wdata = child;
                    w_we    = 1'b1;
                    w_waddr = idx_of(child.id);
                    w_wdata = '{present: 1'b1, pos: r_i};
                    n_i     = child_idx;
                    n_moved = 1'b1;
                    n_state = S_SD_RD;
                end
            end
            S_SU_RD: begin
                ra_a = par;
                n_state = (r_i == '0) ? S_FIN : S_SU_CMP;
            end
            S_SU_CMP: begin
                ra_a = par;
                if (earlier(rd_a, r_elem, r_now)) begin
                    n_state = S_FIN;
                end else begin
                    h_we    = 1'b1;
                    h_wdata = rd_a;
                    w_we    = 1'b1;
                    w_waddr = idx_of(rd_a.id);
                    w_wdata = '{present: 1'b1, pos: r_i};
                    n_i     = par;
                    n_state = S_SU_RD;
                end
            end
            S_FIN: begin
                h_we    = 1'b1;
                w_we    = 1'b1;
                w_waddr = idx_of(r_elem.id);
                w_wdata = '{present: 1'b1, pos: r_i};
                n_state = r_rm ? S_FIN2 : S_REP_RD;
            end
            S_FIN2: begin
                w_we    = 1'b1;
                w_waddr = idx_of(r_rid);
                n_rm    = 1'b0;
                n_state = S_REP_RD;
            end
            S_CQ_RD: begin
                ra_a    = AW'(r_size - SW'(1));
                n_state = (r_size == '0) ? S_REP_RD : S_CQ_WR;
            end
            S_CQ_WR: begin
                w_we    = 1'b1;
                w_waddr = idx_of(rd_a.id);
                n_size  = r_size - SW'(1);
                n_state = S_CQ_RD;
            end
            S_REP_RD: begin
                n_state = S_REP;
            end
            S_REP: begin
                o_emit.data.queue_empty = (r_size == '0);
                o_emit.data.next_due_ms = due_val;
                o_emit.data.timer_count = CNT_W'(r_size);
                o_emit.data.status      = r_status;
                if (r_cmd == CMD_TICK) begin
                    if (r_pend) begin
                        o_emit.valid         = 1'b1;
                        o_emit.data.fired_id = r_fid;
                        o_emit.data.fired    = 1'b1;
                        o_emit.data.last     = !top_due;
                        if (i_out_ready) begin
                            if (top_due) begin
                                n_fid   = rd_a.id;
                                n_i     = '0;
                                n_state = S_RM;
                            end else begin
                                n_state = S_IDLE;
                            end
                        end
                    end else if (top_due) begin
                        n_pend  = 1'b1;
                        n_fid   = rd_a.id;
                        n_i     = '0;
                        n_state = S_RM;
                    end else begin
                        o_emit.valid     = 1'b1;
                        o_emit.data.last = 1'b1;
                        if (i_out_ready) begin
                            n_state = S_IDLE;
                        end
                    end
                end else begin
                    o_emit.valid         = 1'b1;
                    o_emit.data.fired_id = r_fid;
                    o_emit.data.fired    = r_fired;
                    o_emit.data.last     = 1'b1;
                    if (i_out_ready) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_cnt    <= '0;
            r_now    <= '0;
            r_size   <= '0;
            r_rm     <= 1'b0;
            r_moved  <= 1'b0;
            r_pend   <= 1'b0;
            r_cmd    <= CMD_ADD;
            r_status <= ST_OK;
            r_fired  <= 1'b0;
            r_fid    <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_now    <= n_now;
            r_size   <= n_size;
            r_rm     <= n_rm;
            r_moved  <= n_moved;
            r_pend   <= n_pend;
            r_cmd    <= n_cmd;
            r_status <= n_status;
            r_fired  <= n_fired;
            r_fid    <= n_fid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bound <= n_bound;
        r_id    <= n_id;
        r_id_ok <= n_id_ok;
        r_delay <= n_delay;
        r_i     <= n_i;
        r_elem  <= n_elem;
        r_rid   <= n_rid;
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire
